// ----- src/owh_pkg.sv -----
package owh_pkg;

    localparam int DEPTH  = 256;
    localparam int IDX_W  = 8;
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 50;
    localparam int RND_W  = ACC_W - 14;
    localparam int SUM_W  = 48;
    localparam int TRIG_W = 16;
    localparam int MAG_W  = 15;
    localparam int OUT_W  = 40;
    localparam int ENT_W  = 5 * 32 + 2 * 16;
    localparam int EVO_W  = 64;

    // 2^32 / (2*pi), Q0.32
    localparam logic [31:0] INV_TWO_PI = 32'd683565276;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_EVOLVE = 2'd1;
    localparam logic [1:0] OP_GRID   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVOLVE,
        ST_GRID,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_NLOAD,
        ACC_ADD
    } acc_op_t;

    // round half up by 14 bits
    function automatic logic signed [RND_W-1:0] round14(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = v + $signed(ACC_W'(8192));
        return RND_W'(t >>> 14);
    endfunction

    function automatic logic [31:0] sat32(input logic signed [RND_W-1:0] v);
        if (v[RND_W-1:31] == '0 || v[RND_W-1:31] == {(RND_W-31){1'b1}})
            return v[31:0];
        return v[RND_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic logic [OUT_W-1:0] sat40(input logic signed [SUM_W-1:0] v);
        if (v[SUM_W-1:OUT_W-1] == '0 || v[SUM_W-1:OUT_W-1] == {(SUM_W-OUT_W+1){1'b1}})
            return v[OUT_W-1:0];
        return v[SUM_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    endfunction

    // quarter-wave sine magnitude, Q1.14, odd Taylor series to x^9 in Q30
    function automatic int quarter_sin(input int j, input int abits);
        longint x;
        longint x2;
        longint acc;
        x   = longint'(j) <<< (32 - abits);
        x2  = (x * x) >>> 30;
        acc = 172272;
        acc = -5026991 + ((acc * x2) >>> 30);
        acc = 85569306 + ((acc * x2) >>> 30);
        acc = -693598659 + ((acc * x2) >>> 30);
        acc = 1686629713 + ((acc * x2) >>> 30);
        acc = (((acc * x) >>> 30) + 32768) >>> 16;
        if (acc < 0)
            acc = 0;
        if (acc > 16384)
            acc = 16384;
        return int'(acc);
    endfunction

endpackage

// ----- src/owh_ram.sv -----
module owh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/owh_sine_rom.sv -----
module owh_sine_rom #(
    parameter int ANGLE_BITS = 12
) (
    input  logic                               clk,
    input  logic                               rd_en,
    input  logic [ANGLE_BITS-1:0]              angle,
    output logic signed [owh_pkg::TRIG_W-1:0]  value
);

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int AW      = ANGLE_BITS - 1;

    typedef logic [owh_pkg::MAG_W-1:0] rom_t [QUARTER+1];

    function automatic rom_t build_rom();
        rom_t r;
        for (int j = 0; j <= QUARTER; j++)
        begin
            r[j] = owh_pkg::MAG_W'(owh_pkg::quarter_sin(j, ANGLE_BITS));
        end
        return r;
    endfunction

    localparam rom_t ROM = build_rom();

    logic [1:0]                 quad;
    logic [ANGLE_BITS-3:0]      frac;
    logic [AW-1:0]              rom_addr;
    logic [owh_pkg::MAG_W-1:0]  mag_reg;
    logic                       neg_reg;

    assign quad = angle[ANGLE_BITS-1 -: 2];
    assign frac = angle[ANGLE_BITS-3:0];

    // odd quadrants run the quarter table backwards
    assign rom_addr = quad[0] ? (AW'(QUARTER) - AW'(frac)) : AW'(frac);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mag_reg <= ROM[rom_addr];
            neg_reg <= quad[1];
        end
    end

    assign value = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});

endmodule

// ----- src/owh_mac.sv -----
module owh_mac (
    input  logic                                clk,
    input  owh_pkg::acc_op_t                    acc_op,
    input  logic signed [owh_pkg::MUL_W-1:0]    a,
    input  logic signed [owh_pkg::MUL_W-1:0]    b,
    output logic signed [owh_pkg::PROD_W-1:0]   prod,
    output logic signed [owh_pkg::ACC_W-1:0]    acc
);

    logic signed [owh_pkg::PROD_W-1:0] prod_reg;
    logic signed [owh_pkg::ACC_W-1:0]  acc_reg;
    logic signed [owh_pkg::ACC_W-1:0]  acc_next;
    logic signed [owh_pkg::ACC_W-1:0]  addend;

    // accumulated terms always fit the accumulator
    assign addend = $signed(prod_reg[owh_pkg::ACC_W-1:0]);

    always_comb
    begin
        case (acc_op)
            owh_pkg::ACC_LOAD:  acc_next = addend;
            owh_pkg::ACC_NLOAD: acc_next = -addend;
            owh_pkg::ACC_ADD:   acc_next = acc_reg + addend;
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        acc_reg  <= acc_next;
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ----- src/ocean_wave_height_dft.sv -----
// channel  handshake             payload
// in       in_valid / in_ready   opcode, entry_index, start_re/im, mirror_re/im, rate,
//                                heading_x/z, sim_time
// out      out_valid / out_ready point_index, height_re/im, disp_x, disp_z
//
// Evolve and each grid point walk every live entry in steps: one shared 34x34 multiplier with
// its accumulator does every product in turn. Live entries: min(GRID_SIDE^2, 256).
// Busy (in_ready low) from acceptance of an evolve or in-range grid item to the end.
// Reset clears the sequencer and the output valid; tables are undefined until loaded.
// A result waits in the output register; the next item is taken meanwhile, and a
// further grid result holds in its final step until the output register is free.
module ocean_wave_height_dft #(
    parameter int GRID_SIDE  = 16,
    parameter int ANGLE_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          opcode,
    input  logic [7:0]          entry_index,
    input  logic signed [31:0]  start_re,
    input  logic signed [31:0]  start_im,
    input  logic signed [31:0]  mirror_re,
    input  logic signed [31:0]  mirror_im,
    input  logic [31:0]         rate,
    input  logic signed [15:0]  heading_x,
    input  logic signed [15:0]  heading_z,
    input  logic [31:0]         sim_time,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          point_index,
    output logic signed [39:0]  height_re,
    output logic signed [39:0]  height_im,
    output logic signed [39:0]  disp_x,
    output logic signed [39:0]  disp_z
);

    localparam int SIDE_SQ     = GRID_SIDE * GRID_SIDE;
    localparam int ENTRY_COUNT = (SIDE_SQ < owh_pkg::DEPTH) ? SIDE_SQ : owh_pkg::DEPTH;
    localparam int QUARTER     = 1 << (ANGLE_BITS - 2);
    localparam int MOD4        = 4 * GRID_SIDE;
    localparam int RW          = $clog2(MOD4) + 1;
    localparam int CW          = $clog2(GRID_SIDE);
    localparam int GT_N        = 1 << (RW - 1);
    localparam int SH_R        = (2 * FRAC_BITS > 32) ? (2 * FRAC_BITS - 32) : 0;
    localparam int SH_L        = (2 * FRAC_BITS > 32) ? 0 : (32 - 2 * FRAC_BITS);
    localparam int EV_LAST     = 12;
    localparam int GR_LAST     = 10;
    localparam int IW          = owh_pkg::IDX_W;
    localparam int MW          = owh_pkg::MUL_W;

    typedef logic [ANGLE_BITS-1:0] gtab_t [GT_N];
    typedef logic [IW-1:0]         itab_t [owh_pkg::DEPTH];

    // phase residue (mod 4*side) to angle index, rounded
    function automatic gtab_t build_gtab();
        gtab_t t;
        longint v;
        for (int q = 0; q < GT_N; q++)
        begin
            v = ((longint'(q) << ANGLE_BITS) + 2 * GRID_SIDE) / MOD4;
            t[q] = (q < MOD4) ? ANGLE_BITS'(v) : '0;
        end
        return t;
    endfunction

    function automatic itab_t build_row();
        itab_t t;
        for (int i = 0; i < owh_pkg::DEPTH; i++)
        begin
            t[i] = IW'(i / GRID_SIDE);
        end
        return t;
    endfunction

    function automatic itab_t build_col();
        itab_t t;
        for (int i = 0; i < owh_pkg::DEPTH; i++)
        begin
            t[i] = IW'(i % GRID_SIDE);
        end
        return t;
    endfunction

    localparam gtab_t GTAB    = build_gtab();
    localparam itab_t ROW_TAB = build_row();
    localparam itab_t COL_TAB = build_col();

    // residue of -side*(2v-side) mod 4*side
    function automatic logic [RW-1:0] init_of(input logic [IW-1:0] v);
        logic [1:0] k;
        k = 2'(GRID_SIDE) - {v[0], 1'b0};
        return RW'(GRID_SIDE) * RW'(k);
    endfunction

    // residue of 2*(2v-side) mod 4*side
    function automatic logic [RW-1:0] step_of(input logic [IW-1:0] v);
        logic [9:0] f;
        f = {v, 2'b00};
        return (f >= 10'(2 * GRID_SIDE)) ? RW'(f - 10'(2 * GRID_SIDE))
                                         : RW'(f + 10'(2 * GRID_SIDE));
    endfunction

    function automatic logic [RW-1:0] mod_add(input logic [RW-1:0] x, input logic [RW-1:0] y);
        logic [RW-1:0] s;
        s = x + y;
        return (s >= RW'(MOD4)) ? (s - RW'(MOD4)) : s;
    endfunction

    owh_pkg::state_t  state_reg, state_next;
    logic [3:0]       st_reg;
    logic [IW-1:0]    e_reg;
    logic [CW-1:0]    c_reg;
    logic [RW-1:0]    qr_reg, qc_reg, init_c_reg, step_r_reg, step_c_reg;
    logic [31:0]      time_reg;
    logic [IW-1:0]    point_reg;
    logic [31:0]      p_hi_reg;
    logic [63:0]      m1_reg;
    logic [ANGLE_BITS-1:0] angle_reg;
    logic signed [owh_pkg::TRIG_W-1:0] sin_reg, cos_reg;
    logic [31:0]      ev_re_reg;
    logic signed [MW-1:0] ti_reg;
    logic signed [owh_pkg::SUM_W-1:0] sum_re_reg, sum_im_reg, sum_dx_reg, sum_dz_reg;
    logic             out_valid_reg;
    logic [IW-1:0]    point_out_reg;
    logic [owh_pkg::OUT_W-1:0] height_re_reg, height_im_reg, disp_x_reg, disp_z_reg;

    logic in_fire, idx_ok, last_entry, slot_free, ent_wr;
    logic ent_rd, evo_rd, evo_wr, rom_en;
    logic ld_phi, ld_m1, ld_angle, ld_sin, ld_cos, ld_evre, ld_ti;
    logic add_re, add_im, add_dx, add_dz, step_done, out_load;
    logic [ANGLE_BITS-1:0] rom_angle, grid_angle, ev_angle;
    logic [RW-1:0]    qsum, qmod;
    logic [63:0]      p_shift, ev_sum;
    owh_pkg::acc_op_t acc_op;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [owh_pkg::PROD_W-1:0] prod;
    logic signed [owh_pkg::ACC_W-1:0]  acc;
    logic signed [owh_pkg::RND_W-1:0]  rnd;
    logic signed [owh_pkg::TRIG_W-1:0] rom_value;
    logic [owh_pkg::ENT_W-1:0] ent_wdata, ent_rdata;
    logic [owh_pkg::EVO_W-1:0] evo_wdata, evo_rdata;
    logic signed [31:0] ent_hr, ent_hi, ent_mr, ent_mi, evo_er, evo_ei;
    logic [31:0]        ent_rate;
    logic signed [15:0] ent_dx, ent_dz;
    logic [IW-1:0]      pt_row, pt_col;

    assign in_ready   = (state_reg == owh_pkg::ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign idx_ok     = {1'b0, entry_index} < 9'(ENTRY_COUNT);
    assign last_entry = (e_reg == IW'(ENTRY_COUNT - 1));
    assign slot_free  = !out_valid_reg || out_ready;
    assign ent_wr     = in_fire && (opcode == owh_pkg::OP_LOAD) && idx_ok;

    assign ent_wdata = {start_re, start_im, mirror_re, mirror_im, rate, heading_x, heading_z};
    assign ent_hr    = $signed(ent_rdata[191:160]);
    assign ent_hi    = $signed(ent_rdata[159:128]);
    assign ent_mr    = $signed(ent_rdata[127:96]);
    assign ent_mi    = $signed(ent_rdata[95:64]);
    assign ent_rate  = ent_rdata[63:32];
    assign ent_dx    = $signed(ent_rdata[31:16]);
    assign ent_dz    = $signed(ent_rdata[15:0]);
    assign evo_er    = $signed(evo_rdata[63:32]);
    assign evo_ei    = $signed(evo_rdata[31:0]);

    assign rnd       = owh_pkg::round14(acc);
    assign evo_wdata = {ev_re_reg, owh_pkg::sat32(rnd)};

    // time product rescaled to 32 fraction bits, then times 1/(2*pi), low 64 bits
    assign p_shift  = (prod[63:0] >> SH_R) << SH_L;
    assign ev_sum   = m1_reg + {prod[31:0], 32'b0};
    assign ev_angle = ev_sum[63 -: ANGLE_BITS];

    assign qsum       = qr_reg + qc_reg;
    assign qmod       = (qsum >= RW'(MOD4)) ? (qsum - RW'(MOD4)) : qsum;
    assign grid_angle = GTAB[qmod[RW-2:0]];

    assign pt_row = ROW_TAB[entry_index];
    assign pt_col = COL_TAB[entry_index];

    owh_ram #(
        .WIDTH (owh_pkg::ENT_W),
        .DEPTH (owh_pkg::DEPTH)
    ) u_ent_ram (
        .clk     (clk),
        .wr_en   (ent_wr),
        .wr_addr (entry_index),
        .wr_data (ent_wdata),
        .rd_en   (ent_rd),
        .rd_addr (e_reg),
        .rd_data (ent_rdata)
    );

    owh_ram #(
        .WIDTH (owh_pkg::EVO_W),
        .DEPTH (owh_pkg::DEPTH)
    ) u_evo_ram (
        .clk     (clk),
        .wr_en   (evo_wr),
        .wr_addr (e_reg),
        .wr_data (evo_wdata),
        .rd_en   (evo_rd),
        .rd_addr (e_reg),
        .rd_data (evo_rdata)
    );

    owh_sine_rom #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_sine (
        .clk   (clk),
        .rd_en (rom_en),
        .angle (rom_angle),
        .value (rom_value)
    );

    owh_mac u_mac (
        .clk    (clk),
        .acc_op (acc_op),
        .a      (mul_a),
        .b      (mul_b),
        .prod   (prod),
        .acc    (acc)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            owh_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (opcode == owh_pkg::OP_EVOLVE)
                        state_next = owh_pkg::ST_EVOLVE;
                    else if (opcode == owh_pkg::OP_GRID && idx_ok)
                        state_next = owh_pkg::ST_GRID;
                end
            end
            owh_pkg::ST_EVOLVE:
            begin
                if (st_reg == 4'(EV_LAST) && last_entry)
                    state_next = owh_pkg::ST_IDLE;
            end
            owh_pkg::ST_GRID:
            begin
                if (st_reg == 4'(GR_LAST) && last_entry)
                    state_next = owh_pkg::ST_DONE;
            end
            owh_pkg::ST_DONE:
            begin
                if (slot_free)
                    state_next = owh_pkg::ST_IDLE;
            end
            default: state_next = owh_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ent_rd    = 1'b0;
        evo_rd    = 1'b0;
        evo_wr    = 1'b0;
        rom_en    = 1'b0;
        rom_angle = grid_angle;
        acc_op    = owh_pkg::ACC_HOLD;
        mul_a     = '0;
        mul_b     = '0;
        ld_phi    = 1'b0;
        ld_m1     = 1'b0;
        ld_angle  = 1'b0;
        ld_sin    = 1'b0;
        ld_cos    = 1'b0;
        ld_evre   = 1'b0;
        ld_ti     = 1'b0;
        add_re    = 1'b0;
        add_im    = 1'b0;
        add_dx    = 1'b0;
        add_dz    = 1'b0;
        step_done = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            owh_pkg::ST_EVOLVE:
            begin
                case (st_reg)
                    4'd0: ent_rd = 1'b1;
                    4'd1:
                    begin
                        mul_a = MW'(ent_rate);
                        mul_b = MW'(time_reg);
                    end
                    4'd2:
                    begin
                        ld_phi = 1'b1;
                        mul_a  = MW'(p_shift[31:0]);
                        mul_b  = MW'(owh_pkg::INV_TWO_PI);
                    end
                    4'd3:
                    begin
                        ld_m1 = 1'b1;
                        mul_a = MW'(p_hi_reg);
                        mul_b = MW'(owh_pkg::INV_TWO_PI);
                    end
                    4'd4:
                    begin
                        rom_en    = 1'b1;
                        rom_angle = ev_angle;
                        ld_angle  = 1'b1;
                    end
                    4'd5:
                    begin
                        ld_sin    = 1'b1;
                        rom_en    = 1'b1;
                        rom_angle = angle_reg + ANGLE_BITS'(QUARTER);
                    end
                    4'd6: ld_cos = 1'b1;
                    // re = (h0+m).re*c + (m.im-h0.im)*s, im = (h0-m).re*s + (h0+m).im*c
                    4'd7:
                    begin
                        mul_a = MW'(ent_hr) + MW'(ent_mr);
                        mul_b = MW'(cos_reg);
                    end
                    4'd8:
                    begin
                        acc_op = owh_pkg::ACC_LOAD;
                        mul_a  = MW'(ent_mi) - MW'(ent_hi);
                        mul_b  = MW'(sin_reg);
                    end
                    4'd9:
                    begin
                        acc_op = owh_pkg::ACC_ADD;
                        mul_a  = MW'(ent_hr) - MW'(ent_mr);
                        mul_b  = MW'(sin_reg);
                    end
                    4'd10:
                    begin
                        ld_evre = 1'b1;
                        acc_op  = owh_pkg::ACC_LOAD;
                        mul_a   = MW'(ent_hi) + MW'(ent_mi);
                        mul_b   = MW'(cos_reg);
                    end
                    4'd11: acc_op = owh_pkg::ACC_ADD;
                    4'd12:
                    begin
                        evo_wr    = 1'b1;
                        step_done = 1'b1;
                    end
                    default: ;
                endcase
            end
            owh_pkg::ST_GRID:
            begin
                case (st_reg)
                    4'd0:
                    begin
                        ent_rd   = 1'b1;
                        evo_rd   = 1'b1;
                        rom_en   = 1'b1;
                        ld_angle = 1'b1;
                    end
                    4'd1:
                    begin
                        ld_sin    = 1'b1;
                        rom_en    = 1'b1;
                        rom_angle = angle_reg + ANGLE_BITS'(QUARTER);
                    end
                    4'd2:
                    begin
                        ld_cos = 1'b1;
                        mul_a  = MW'(evo_ei);
                        mul_b  = MW'(sin_reg);
                    end
                    4'd3:
                    begin
                        acc_op = owh_pkg::ACC_NLOAD;
                        mul_a  = MW'(evo_er);
                        mul_b  = MW'(cos_reg);
                    end
                    4'd4:
                    begin
                        acc_op = owh_pkg::ACC_ADD;
                        mul_a  = MW'(evo_er);
                        mul_b  = MW'(sin_reg);
                    end
                    4'd5:
                    begin
                        add_re = 1'b1;
                        acc_op = owh_pkg::ACC_LOAD;
                        mul_a  = MW'(evo_ei);
                        mul_b  = MW'(cos_reg);
                    end
                    4'd6: acc_op = owh_pkg::ACC_ADD;
                    4'd7:
                    begin
                        add_im = 1'b1;
                        ld_ti  = 1'b1;
                        mul_a  = MW'(ent_dx);
                        mul_b  = MW'(rnd);
                    end
                    4'd8:
                    begin
                        acc_op = owh_pkg::ACC_LOAD;
                        mul_a  = MW'(ent_dz);
                        mul_b  = ti_reg;
                    end
                    4'd9:
                    begin
                        add_dx = 1'b1;
                        acc_op = owh_pkg::ACC_LOAD;
                    end
                    4'd10:
                    begin
                        add_dz    = 1'b1;
                        step_done = 1'b1;
                    end
                    default: ;
                endcase
            end
            owh_pkg::ST_DONE: out_load = slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= owh_pkg::ST_IDLE;
            st_reg        <= '0;
            e_reg         <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                st_reg <= '0;
                e_reg  <= '0;
                c_reg  <= '0;
            end
            else if (step_done)
            begin
                st_reg <= '0;
                e_reg  <= e_reg + 1'b1;
                c_reg  <= (c_reg == CW'(GRID_SIDE - 1)) ? '0 : c_reg + 1'b1;
            end
            else if (state_reg == owh_pkg::ST_EVOLVE || state_reg == owh_pkg::ST_GRID)
            begin
                st_reg <= st_reg + 1'b1;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            time_reg   <= sim_time;
            point_reg  <= entry_index;
            qr_reg     <= init_of(pt_row);
            qc_reg     <= init_of(pt_col);
            init_c_reg <= init_of(pt_col);
            step_r_reg <= step_of(pt_row);
            step_c_reg <= step_of(pt_col);
            sum_re_reg <= '0;
            sum_im_reg <= '0;
            sum_dx_reg <= '0;
            sum_dz_reg <= '0;
        end
        else
        begin
            if (step_done)
            begin
                // next column, or wrap to the next row
                if (c_reg == CW'(GRID_SIDE - 1))
                begin
                    qc_reg <= init_c_reg;
                    qr_reg <= mod_add(qr_reg, step_r_reg);
                end
                else
                begin
                    qc_reg <= mod_add(qc_reg, step_c_reg);
                end
            end
            if (add_re)
                sum_re_reg <= sum_re_reg + owh_pkg::SUM_W'(rnd);
            if (add_im)
                sum_im_reg <= sum_im_reg + owh_pkg::SUM_W'(rnd);
            if (add_dx)
                sum_dx_reg <= sum_dx_reg + owh_pkg::SUM_W'(rnd);
            if (add_dz)
                sum_dz_reg <= sum_dz_reg + owh_pkg::SUM_W'(rnd);
        end
        if (ld_phi)
            p_hi_reg <= p_shift[63:32];
        if (ld_m1)
            m1_reg <= prod[63:0];
        if (ld_angle)
            angle_reg <= rom_angle;
        if (ld_sin)
            sin_reg <= rom_value;
        if (ld_cos)
            cos_reg <= rom_value;
        if (ld_evre)
            ev_re_reg <= owh_pkg::sat32(rnd);
        if (ld_ti)
            ti_reg <= MW'(rnd);
        if (out_load)
        begin
            point_out_reg <= point_reg;
            height_re_reg <= owh_pkg::sat40(sum_re_reg);
            height_im_reg <= owh_pkg::sat40(sum_im_reg);
            disp_x_reg    <= owh_pkg::sat40(sum_dx_reg);
            disp_z_reg    <= owh_pkg::sat40(sum_dz_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign point_index = point_out_reg;
    assign height_re   = $signed(height_re_reg);
    assign height_im   = $signed(height_im_reg);
    assign disp_x      = $signed(disp_x_reg);
    assign disp_z      = $signed(disp_z_reg);

    a_grid_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && opcode == owh_pkg::OP_GRID && idx_ok) |=> state_reg == owh_pkg::ST_GRID)
        else $error("grid item did not start the entry walk");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == owh_pkg::ST_GRID |-> st_reg <= 4'(GR_LAST)) and
        (state_reg == owh_pkg::ST_EVOLVE |-> st_reg <= 4'(EV_LAST)))
        else $error("sequencer step out of range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == owh_pkg::ST_DONE)
        else $error("result raised outside the final step");

    a_evo_write: assert property (@(posedge clk) disable iff (!rst_n)
        evo_wr |-> $past(st_reg) == 4'(EV_LAST - 1) && $past(state_reg) == owh_pkg::ST_EVOLVE)
        else $error("evolved entry written before its sum completed");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int ENTRIES = 256;
    localparam int SIDE = 16;
    localparam int ABITS = 12;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 8000;
    localparam int DRAIN_CYCLES = 3400;

    typedef struct {
        logic [1:0]         op;
        logic [7:0]         idx;
        logic signed [31:0] sre;
        logic signed [31:0] sim;
        logic signed [31:0] mre;
        logic signed [31:0] mim;
        logic [31:0]        rt;
        logic signed [15:0] hx;
        logic signed [15:0] hz;
        logic [31:0]        tm;
    } wave_item_t;

    typedef struct {
        logic [7:0]         pt;
        logic signed [39:0] hre;
        logic signed [39:0] him;
        logic signed [39:0] dx;
        logic signed [39:0] dz;
    } height_res_t;

    typedef struct {
        wave_item_t  it;
        bit          has_exp;
        height_res_t exp_res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [1:0] opcode;
    logic [7:0] entry_index;
    logic signed [31:0] start_re, start_im, mirror_re, mirror_im;
    logic [31:0] rate;
    logic signed [15:0] heading_x, heading_z;
    logic [31:0] sim_time;
    logic out_valid;
    logic out_ready;
    logic [7:0] point_index;
    logic signed [39:0] height_re, height_im, disp_x, disp_z;

    ocean_wave_height_dft dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .entry_index(entry_index),
        .start_re(start_re), .start_im(start_im),
        .mirror_re(mirror_re), .mirror_im(mirror_im),
        .rate(rate), .heading_x(heading_x), .heading_z(heading_z),
        .sim_time(sim_time),
        .out_valid(out_valid), .out_ready(out_ready),
        .point_index(point_index),
        .height_re(height_re), .height_im(height_im),
        .disp_x(disp_x), .disp_z(disp_z)
    );

    // sea state as the block should hold it
    logic signed [31:0] amp0_re[ENTRIES], amp0_im[ENTRIES];
    logic signed [31:0] ampm_re[ENTRIES], ampm_im[ENTRIES];
    logic [31:0]        omega[ENTRIES];
    logic signed [15:0] dir_x[ENTRIES], dir_z[ENTRIES];
    logic signed [31:0] amp_t_re[ENTRIES], amp_t_im[ENTRIES];
    int                 sine_lut[1 << ABITS];

    height_res_t heights_due[$];
    dir_row_t    rows[$];
    int  errors = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 0;
    int  quiet_cycles = 0;

    function automatic longint rnd14(input longint v);
        return (v + 64'sd8192) >>> 14;
    endfunction

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Taylor series of sin(pi/2*x) in Q30, Horner with floored products
    function automatic int quarter_wave(input int j);
        longint x, x2, a;
        x  = longint'(j) <<< (32 - ABITS);
        x2 = (x * x) >>> 30;
        a  = 172272;
        a  = -64'sd5026991 + ((a * x2) >>> 30);
        a  = 64'sd85569306 + ((a * x2) >>> 30);
        a  = -64'sd693598659 + ((a * x2) >>> 30);
        a  = 64'sd1686629713 + ((a * x2) >>> 30);
        a  = (((a * x) >>> 30) + 32768) >>> 16;
        if (a < 0)
            a = 0;
        if (a > 16384)
            a = 16384;
        return int'(a);
    endfunction

    function automatic longint sin_at(input int a);
        return longint'(sine_lut[a & ((1 << ABITS) - 1)]);
    endfunction

    function automatic longint cos_at(input int a);
        return longint'(sine_lut[(a + (1 << (ABITS - 2))) & ((1 << ABITS) - 1)]);
    endfunction

    function automatic int phase_of_time(input logic [31:0] w, input logic [31:0] t);
        logic [63:0] p, s;
        p = 64'(w) * 64'(t);
        s = p * 64'(owh_pkg::INV_TWO_PI);
        return int'(s[63:64-ABITS]);
    endfunction

    function automatic int phase_of_point(input int e, input int pt);
        longint q;
        q = (2 * (e / SIDE) - SIDE) * (2 * (pt / SIDE) - SIDE)
          + (2 * (e % SIDE) - SIDE) * (2 * (pt % SIDE) - SIDE);
        q = q % (4 * SIDE);
        if (q < 0)
            q += 4 * SIDE;
        return int'((((q <<< ABITS) + 2 * SIDE) / (4 * SIDE)) & ((1 << ABITS) - 1));
    endfunction

    task automatic sea_step(input wave_item_t it, output bit has, output height_res_t r);
        longint c, s, re, im, tr, ti, sr, si, dx, dz;
        int a;
        has = 0;
        r = '{default: '0};
        case (it.op)
            owh_pkg::OP_LOAD:
            begin
                amp0_re[it.idx] = it.sre;
                amp0_im[it.idx] = it.sim;
                ampm_re[it.idx] = it.mre;
                ampm_im[it.idx] = it.mim;
                omega[it.idx]   = it.rt;
                dir_x[it.idx]   = it.hx;
                dir_z[it.idx]   = it.hz;
            end
            owh_pkg::OP_EVOLVE:
            begin
                for (int e = 0; e < ENTRIES; e++)
                begin
                    a  = phase_of_time(omega[e], it.tm);
                    c  = cos_at(a);
                    s  = sin_at(a);
                    re = amp0_re[e] * c - amp0_im[e] * s + ampm_re[e] * c + ampm_im[e] * s;
                    im = amp0_re[e] * s + amp0_im[e] * c + ampm_im[e] * c - ampm_re[e] * s;
                    amp_t_re[e] = 32'(clamp(rnd14(re), 32));
                    amp_t_im[e] = 32'(clamp(rnd14(im), 32));
                end
            end
            owh_pkg::OP_GRID:
            begin
                sr = 0; si = 0; dx = 0; dz = 0;
                for (int e = 0; e < ENTRIES; e++)
                begin
                    a  = phase_of_point(e, int'(it.idx));
                    c  = cos_at(a);
                    s  = sin_at(a);
                    tr = rnd14(amp_t_re[e] * c - amp_t_im[e] * s);
                    ti = rnd14(amp_t_re[e] * s + amp_t_im[e] * c);
                    sr += tr;
                    si += ti;
                    dx += rnd14(longint'(dir_x[e]) * ti);
                    dz += rnd14(longint'(dir_z[e]) * ti);
                end
                has   = 1;
                r.pt  = it.idx;
                r.hre = 40'(clamp(sr, 40));
                r.him = 40'(clamp(si, 40));
                r.dx  = 40'(clamp(dx, 40));
                r.dz  = 40'(clamp(dz, 40));
            end
            default: ;
        endcase
    endtask

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (heights_due.size() == 0)
            begin
                $error("result for point %0d with no item outstanding", point_index);
                errors++;
            end
            else
            begin
                height_res_t x;
                x = heights_due.pop_front();
                if (point_index !== x.pt)
                begin
                    $error("point_index expected %0d got %0d", x.pt, point_index);
                    errors++;
                end
                if (height_re !== x.hre)
                begin
                    $error("height_re expected %0d got %0d", x.hre, height_re);
                    errors++;
                end
                if (height_im !== x.him)
                begin
                    $error("height_im expected %0d got %0d", x.him, height_im);
                    errors++;
                end
                if (disp_x !== x.dx)
                begin
                    $error("disp_x expected %0d got %0d", x.dx, disp_x);
                    errors++;
                end
                if (disp_z !== x.dz)
                begin
                    $error("disp_z expected %0d got %0d", x.dz, disp_z);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // called at a rising edge; returns at the edge that takes the item
    task automatic send_item(input wave_item_t it, input bit typed, input height_res_t t_res);
        bit has;
        height_res_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= it.op;
        entry_index <= it.idx;
        start_re    <= it.sre;
        start_im    <= it.sim;
        mirror_re   <= it.mre;
        mirror_im   <= it.mim;
        rate        <= it.rt;
        heading_x   <= it.hx;
        heading_z   <= it.hz;
        sim_time    <= it.tm;
        do
            @(posedge clk);
        while (!in_ready);
        sea_step(it, has, r);
        if (has)
        begin
            if (typed)
                r = t_res;
            heights_due = {heights_due, r};
        end
    endtask

    function automatic wave_item_t mk(input logic [1:0] op, input logic [7:0] idx,
                                      input logic [31:0] sre, input logic [31:0] sim,
                                      input logic [31:0] mre, input logic [31:0] mim,
                                      input logic [31:0] rt, input logic [15:0] hx,
                                      input logic [15:0] hz, input logic [31:0] tm);
        wave_item_t it;
        it = '{op, idx, sre, sim, mre, mim, rt, hx, hz, tm};
        return it;
    endfunction

    function automatic void add_row(input wave_item_t it, input bit has_exp,
                                    input height_res_t exp_res);
        dir_row_t row;
        row.it      = it;
        row.has_exp = has_exp;
        row.exp_res = exp_res;
        rows = {rows, row};
    endfunction

    function automatic wave_item_t random_item(input logic [1:0] op);
        wave_item_t it;
        it.op  = op;
        it.idx = 8'($urandom_range(255));
        it.sre = $urandom;
        it.sim = $urandom;
        it.mre = $urandom;
        it.mim = $urandom;
        it.rt  = $urandom;
        it.hx  = 16'($signed($urandom_range(32768)) - 16384);
        it.hz  = 16'($signed($urandom_range(32768)) - 16384);
        it.tm  = $urandom;
        // amplitudes often modest so sums stay in range and the DFT is exercised
        if ($urandom_range(3) != 0)
        begin
            it.sre = $signed(it.sre) >>> $urandom_range(20, 8);
            it.sim = $signed(it.sim) >>> $urandom_range(20, 8);
            it.mre = $signed(it.mre) >>> $urandom_range(20, 8);
            it.mim = $signed(it.mim) >>> $urandom_range(20, 8);
        end
        return it;
    endfunction

    function automatic logic [1:0] pick_op();
        int w;
        w = $urandom_range(99);
        if (w < 78)
            return owh_pkg::OP_LOAD;
        if (w < 84)
            return owh_pkg::OP_EVOLVE;
        if (w < 96)
            return owh_pkg::OP_GRID;
        return OP_NONE;
    endfunction

    initial
    begin
        height_res_t none_res;
        height_res_t flat;
        wave_item_t it;
        int q, r, m;

        in_valid = 0; opcode = owh_pkg::OP_LOAD; entry_index = 0;
        start_re = 0; start_im = 0; mirror_re = 0; mirror_im = 0;
        rate = 0; heading_x = 0; heading_z = 0; sim_time = 0;
        rst_n = 0;
        none_res = '{default: '0};

        for (int i = 0; i < (1 << ABITS); i++)
        begin
            q = i >> (ABITS - 2);
            r = i & ((1 << (ABITS - 2)) - 1);
            m = (q & 1) ? quarter_wave((1 << (ABITS - 2)) - r) : quarter_wave(r);
            sine_lut[i] = (q & 2) ? -m : m;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every entry is written before anything reads it: flat sea, random rates
        for (int e = 0; e < ENTRIES; e++)
        begin
            it = random_item(owh_pkg::OP_LOAD);
            it.idx = 8'(e);
            it.sre = 0; it.sim = 0; it.mre = 0; it.mim = 0;
            send_item(it, 0, none_res);
        end

        flat = '{default: '0};
        add_row(mk(owh_pkg::OP_EVOLVE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res);
        flat.pt = 8'd0;
        add_row(mk(owh_pkg::OP_GRID, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, flat);
        flat.pt = 8'd255;
        add_row(mk(owh_pkg::OP_GRID, 255, 0, 0, 0, 0, 0, 0, 0, 0), 1, flat);
        add_row(mk(owh_pkg::OP_LOAD, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'hFFFF_FFFF, 16'sd16384, -16'sd16384, 0),
                0, none_res);
        add_row(mk(owh_pkg::OP_LOAD, 255, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h7FFF_FFFF, 0, -16'sd16384, 16'sd16384, 32'hFFFF_FFFF),
                0, none_res);
        add_row(mk(owh_pkg::OP_LOAD, 136, 32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0, 0, 0),
                0, none_res);
        add_row(mk(OP_NONE, 7, 32'h1234_5678, 1, 2, 3, 4, 5, 6, 7), 0, none_res);
        add_row(mk(OP_NONE, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF),
                0, none_res);
        // at time zero, entry 0 saturates: start and mirror both at full scale
        add_row(mk(owh_pkg::OP_EVOLVE, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res);
        add_row(mk(owh_pkg::OP_GRID, 136, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res);
        add_row(mk(owh_pkg::OP_GRID, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res);
        add_row(mk(owh_pkg::OP_GRID, 255, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res);
        add_row(mk(owh_pkg::OP_EVOLVE, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 0, none_res);
        add_row(mk(owh_pkg::OP_GRID, 17, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res);
        add_row(mk(owh_pkg::OP_GRID, 136, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res);
        add_row(mk(owh_pkg::OP_LOAD, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, -16'sd16384, -16'sd16384, 0),
                0, none_res);
        add_row(mk(owh_pkg::OP_EVOLVE, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0001_0000), 0, none_res);
        add_row(mk(owh_pkg::OP_GRID, 8, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res);
        add_row(mk(owh_pkg::OP_EVOLVE, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0003_243F), 0, none_res);
        add_row(mk(owh_pkg::OP_GRID, 128, 0, 0, 0, 0, 0, 0, 0, 0), 0, none_res);

        foreach (rows[i])
            send_item(rows[i].it, rows[i].has_exp, rows[i].exp_res);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1) ? 59 : (ph == 3) ? 31 : 0;
            recv_stall_pct = (ph == 2) ? 59 : (ph == 3) ? 31 : 0;
            if (ph == 0)
            begin
                // long receiver hold-off while grid points keep coming
                hold_req = 1;
                repeat (3)
                    send_item(random_item(owh_pkg::OP_GRID), 0, none_res);
            end
            repeat (130)
                send_item(random_item(pick_op()), 0, none_res);
        end

        in_valid <= 1'b0;
        while (heights_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
